// ----- sv/tmcw_pkg.sv -----
// Shared types and constants for the text-mode console writer.
`timescale 1ns / 1ps
package tmcw_pkg;

	// Request codes
	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// Control characters
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_BS  = 8'h08;

	// Blank cell contents
	localparam logic [7:0] BLANK_CHAR  = 8'h20;
	localparam logic [7:0] BLANK_STYLE = 8'h07;

	// Backspace only acts above this column
	localparam int BS_MIN_COL = 2;

	// Datapath operations issued by the controller
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_PUT,
		CMD_READ,
		CMD_CLEAR,
		CMD_SCR_RD,
		CMD_SCR_WR,
		CMD_FILL
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic out_load;
	} ctl_t;

	typedef struct packed {
		logic [1:0] req;
		logic       overflow;
		logic       scr_last;
		logic       fill_last;
		logic       out_free;
	} sts_t;

endpackage

// ----- sv/tmcw_dp.sv -----
// Datapath: cell memory, cursor, sweep counter, request and result registers.
`timescale 1ns / 1ps
module tmcw_dp import tmcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	output sts_t        sts,
	input  logic [1:0]  req_type,
	input  logic [7:0]  char_code,
	input  logic [3:0]  fg_color,
	input  logic [10:0] cell_index,
	input  logic        cfg_valid,
	input  logic [3:0]  background_color,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] cursor_loc,
	output logic [7:0]  read_char,
	output logic [7:0]  read_style
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int PW    = $clog2(CELLS + COLUMNS);
	localparam int CLW   = $clog2(COLUMNS + 8);
	localparam int XW    = (PW > 11) ? PW : 11;

	logic [1:0]     req_q;
	logic [7:0]     ch_q;
	logic [3:0]     fg_q;
	logic [10:0]    idx_q;
	logic [3:0]     bg_q;
	logic [PW-1:0]  pos_q;
	logic [CLW-1:0] col_q;
	logic [AW-1:0]  cnt_q;
	logic [15:0]    rd_q;
	logic           out_valid_q;

	logic [15:0]    cells_mem [CELLS];

	logic [PW-1:0]  pos_n;
	logic [CLW-1:0] col_n;
	logic [CLW-1:0] col_t;
	logic           put_we;
	logic [AW-1:0]  put_wa;
	logic [15:0]    put_wd;
	logic           overflow;
	logic           idx_ok;

	logic           we;
	logic [AW-1:0]  wa;
	logic [15:0]    wd;
	logic           re;
	logic [AW-1:0]  ra;

	assign idx_ok = XW'(idx_q) < XW'(CELLS);

	// Work out the cursor move and cell write of a put
	always_comb begin
		pos_n  = pos_q;
		col_n  = col_q;
		col_t  = '0;
		put_we = 1'b0;
		put_wa = AW'(pos_q);
		put_wd = {ch_q, bg_q, fg_q};
		case (ch_q)
			CH_NL: begin
				pos_n = pos_q - PW'(col_q) + PW'(COLUMNS);
				col_n = '0;
			end
			CH_TAB: begin
				pos_n = {pos_q[PW-1:3] + 1'b1, 3'b000};
				col_t = col_q + CLW'(4'd8 - {1'b0, pos_q[2:0]});
				col_n = (col_t >= CLW'(COLUMNS)) ? col_t - CLW'(COLUMNS) : col_t;
			end
			CH_BS: begin
				if (col_q > CLW'(BS_MIN_COL)) begin
					pos_n  = pos_q - 1'b1;
					col_n  = col_q - 1'b1;
					put_we = 1'b1;
					put_wa = AW'(pos_q - 1'b1);
					put_wd = {BLANK_CHAR, BLANK_STYLE};
				end
			end
			default: begin
				pos_n  = pos_q + 1'b1;
				col_t  = col_q + 1'b1;
				col_n  = (col_t == CLW'(COLUMNS)) ? '0 : col_t;
				put_we = 1'b1;
			end
		endcase
	end

	assign overflow = pos_n >= PW'(CELLS);

	// Select the memory port addresses and data
	always_comb begin
		we = 1'b0;
		wa = cnt_q;
		wd = {BLANK_CHAR, BLANK_STYLE};
		re = 1'b0;
		ra = cnt_q + AW'(COLUMNS);
		case (ctl.cmd)
			CMD_PUT: begin
				we = put_we;
				wa = put_wa;
				wd = put_wd;
			end
			CMD_FILL: begin
				we = 1'b1;
			end
			CMD_SCR_WR: begin
				we = 1'b1;
				wd = rd_q;
			end
			CMD_SCR_RD: begin
				re = 1'b1;
			end
			CMD_READ: begin
				re = idx_ok;
				ra = AW'(idx_q);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Cell memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			cells_mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= cells_mem[ra];
		end
	end

	// Capture request fields on an accepted beat
	always_ff @(posedge clk) begin
		if (ctl.cmd == CMD_LOAD) begin
			req_q <= req_type;
			ch_q  <= char_code;
			fg_q  <= fg_color;
			idx_q <= cell_index;
		end
	end

	// Cursor, sweep counter and background colour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			col_q <= '0;
			cnt_q <= '0;
			bg_q  <= '0;
		end else begin
			if (cfg_valid) begin
				bg_q <= background_color;
			end
			case (ctl.cmd)
				CMD_PUT: begin
					cnt_q <= '0;
					if (overflow) begin
						pos_q <= PW'(CELLS - COLUMNS);
						col_q <= '0;
					end else begin
						pos_q <= pos_n;
						col_q <= col_n;
					end
				end
				CMD_CLEAR: begin
					pos_q <= '0;
					col_q <= '0;
					cnt_q <= '0;
				end
				CMD_FILL, CMD_SCR_WR: begin
					cnt_q <= cnt_q + 1'b1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			cursor_loc <= 11'(pos_q);
			if (req_q == REQ_READ && idx_ok) begin
				read_char  <= rd_q[15:8];
				read_style <= rd_q[7:0];
			end else begin
				read_char  <= '0;
				read_style <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

	assign sts.req       = req_q;
	assign sts.overflow  = overflow;
	assign sts.scr_last  = cnt_q == AW'(CELLS - COLUMNS - 1);
	assign sts.fill_last = cnt_q == AW'(CELLS - 1);
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

// ----- sv/tmcw_ctrl.sv -----
// Controller: sequences each request, the scroll copy and the blanking sweeps.
`timescale 1ns / 1ps
module tmcw_ctrl import tmcw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output ctl_t ctl
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCR_RD,
		ST_SCR_WR,
		ST_FILL,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   pend_q;

	assign in_ready = (state_q == ST_IDLE);

	// Commands for the current state
	always_comb begin
		ctl.cmd      = CMD_NONE;
		ctl.out_load = 1'b0;
		case (state_q)
			ST_IDLE:   ctl.cmd = in_valid ? CMD_LOAD : CMD_NONE;
			ST_EXEC: begin
				case (sts.req)
					REQ_PUT:   ctl.cmd = CMD_PUT;
					REQ_READ:  ctl.cmd = CMD_READ;
					REQ_CLEAR: ctl.cmd = CMD_CLEAR;
					default:   ctl.cmd = CMD_NONE;
				endcase
			end
			ST_SCR_RD: ctl.cmd = CMD_SCR_RD;
			ST_SCR_WR: ctl.cmd = CMD_SCR_WR;
			ST_FILL:   ctl.cmd = CMD_FILL;
			ST_DONE:   ctl.out_load = sts.out_free;
			default:   ctl.cmd = CMD_NONE;
		endcase
	end

	// Advance the state; reset starts with a blanking sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (sts.req)
						REQ_PUT:   state_q <= sts.overflow ? ST_SCR_RD : ST_DONE;
						REQ_CLEAR: begin
							state_q <= ST_FILL;
							pend_q  <= 1'b1;
						end
						default:   state_q <= ST_DONE;
					endcase
				end
				ST_SCR_RD: state_q <= ST_SCR_WR;
				ST_SCR_WR: begin
					if (sts.scr_last) begin
						state_q <= ST_FILL;
						pend_q  <= 1'b1;
					end else begin
						state_q <= ST_SCR_RD;
					end
				end
				ST_FILL: begin
					if (sts.fill_last) begin
						state_q <= pend_q ? ST_DONE : ST_IDLE;
						pend_q  <= 1'b0;
					end
				end
				ST_DONE: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/text_mode_console_writer.sv -----
// Top level of the text-mode console writer.
`timescale 1ns / 1ps
// Text-mode screen engine with a COLUMNS x ROWS grid of character/style cells
// held in a single-port-write, registered-read memory. One request is handled
// at a time. A read, an unused code or a put that does not scroll steps through
// acceptance, execution and the loading of the result register before its result
// beat, in the controller's sequence. A put that runs past the last cell
// scrolls: the copy moves each of the COLUMNS*ROWS-COLUMNS cells up one row
// by a read on the memory's read port and a write on its write port; then the
// last row is blanked. A clear request blanks all COLUMNS*ROWS cells, one per
// cycle. After reset the same clearing pass runs before in_ready rises;
// background_color writes are taken at any time.
// The result register lets a new request in while a result waits.
module text_mode_console_writer import tmcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  char_code,
	input  logic [3:0]  fg_color,
	input  logic [10:0] cell_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] cursor_loc,
	output logic [7:0]  read_char,
	output logic [7:0]  read_style,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  background_color
);

	ctl_t ctl;
	sts_t sts;

	assign cfg_ready = 1'b1;

	tmcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	tmcw_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.sts              (sts),
		.req_type         (req_type),
		.char_code        (char_code),
		.fg_color         (fg_color),
		.cell_index       (cell_index),
		.cfg_valid        (cfg_valid),
		.background_color (background_color),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.cursor_loc       (cursor_loc),
		.read_char        (read_char),
		.read_style       (read_style)
	);

endmodule

// ----- sv/tmcw_checker.sv -----
// Port-level checks for the text-mode console writer, bound to the top level.
`timescale 1ns / 1ps
module tmcw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  req_type,
	input logic [7:0]  char_code,
	input logic [3:0]  fg_color,
	input logic [10:0] cell_index,
	input logic        out_valid,
	input logic        out_ready,
	input logic [10:0] cursor_loc,
	input logic [7:0]  read_char,
	input logic [7:0]  read_style,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [3:0]  background_color
);

	localparam int CELLS = COLUMNS * ROWS;

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cursor_loc)
			&& $stable(read_char) && $stable(read_style))
		else $error("result beat changed while stalled");

	// The reported cursor always lies on the grid
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(cursor_loc) < 32'(CELLS))
		else $error("cursor beyond last cell");

	// One request at a time: no accept in the cycle after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// A result never appears straight after an accept that found no result waiting
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind text_mode_console_writer tmcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tmcw_checker (.*);

// ----- tb/sv/text_mode_console_writer_test.sv -----
// Self-checking testbench for the text-mode console writer.
`timescale 1ns / 1ps
module text_mode_console_writer_test;
	import tmcw_pkg::*;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	// Request code the block leaves unused
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// Once this many scrolls have been seen, a cursor on the last row is sent home
	// with a clear instead, so the long copy passes cannot swamp the run.
	localparam int SCROLL_CAP         = 100;
	localparam int RANDOM_PHASES      = 4;
	localparam int RANDOM_PHASE_ITEMS = 475;
	localparam int CYCLE_LIMIT        = 3_000_000;
	localparam int SETTLE_CYCLES      = 40;

	typedef struct packed {
		logic [10:0] cursor;
		logic [7:0]  ch;
		logic [7:0]  style;
	} console_view_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [7:0]  char_code;
	logic [3:0]  fg_color;
	logic [10:0] cell_index;
	logic        out_valid;
	logic        out_ready;
	logic [10:0] cursor_loc;
	logic [7:0]  read_char;
	logic [7:0]  read_style;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  background_color;

	// Shadow copy of the screen, cursor and background register
	logic [7:0] shadow_char [CELLS];
	logic [7:0] shadow_style [CELLS];
	int         shadow_cursor;
	logic [3:0] shadow_bg;
	int         scrolls_seen;

	console_view_t awaited_views [$];
	int            mismatches;
	int            cycles;
	int            burst_left;

	text_mode_console_writer #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.char_code(char_code),
		.fg_color(fg_color),
		.cell_index(cell_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cursor_loc(cursor_loc),
		.read_char(read_char),
		.read_style(read_style),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.background_color(background_color)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Abandon the run if it hangs
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("text_mode_console_writer_test: FAIL");
			$finish;
		end
	end

	function automatic void blank_screen();
		for (int i = 0; i < CELLS; i++) begin
			shadow_char[i]  = BLANK_CHAR;
			shadow_style[i] = BLANK_STYLE;
		end
		shadow_cursor = 0;
	endfunction

	function automatic void scroll_screen();
		for (int i = 0; i < CELLS - COLUMNS; i++) begin
			shadow_char[i]  = shadow_char[i + COLUMNS];
			shadow_style[i] = shadow_style[i + COLUMNS];
		end
		for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
			shadow_char[i]  = BLANK_CHAR;
			shadow_style[i] = BLANK_STYLE;
		end
		shadow_cursor = CELLS - COLUMNS;
		scrolls_seen++;
	endfunction

	// Advance the shadow screen by one request and return the view it should report
	function automatic console_view_t apply_request(logic [1:0] req, logic [7:0] ch,
			logic [3:0] fg, logic [10:0] idx);
		console_view_t view;
		int pos;
		view = '0;
		case (req)
			REQ_PUT: begin
				pos = shadow_cursor;
				if (ch == CH_NL) begin
					pos = (pos / COLUMNS + 1) * COLUMNS;
				end else if (ch == CH_TAB) begin
					pos = ((pos >> 3) + 1) << 3;
				end else if (ch == CH_BS) begin
					// near the left margin backspace does nothing at all
					if (pos % COLUMNS > BS_MIN_COL) begin
						pos--;
						shadow_char[pos]  = BLANK_CHAR;
						shadow_style[pos] = BLANK_STYLE;
					end
				end else begin
					shadow_char[pos]  = ch;
					shadow_style[pos] = {shadow_bg, fg};
					pos++;
				end
				if (pos >= CELLS + COLUMNS)
					blank_screen();
				else if (pos >= CELLS)
					scroll_screen();
				else
					shadow_cursor = pos;
			end
			REQ_READ: begin
				if (idx < CELLS) begin
					view.ch    = shadow_char[idx];
					view.style = shadow_style[idx];
				end
			end
			REQ_CLEAR: blank_screen();
			default: ;
		endcase
		view.cursor = 11'(shadow_cursor);
		return view;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		mismatches++;
		$display("mismatch on %s: got 0x%h, want 0x%h (cycle %0d)", what, got, want, cycles);
	endtask

	// Compare each result beat with the oldest awaited view
	always @(posedge clk) begin : check_results
		console_view_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_views.size() == 0) begin
				report_mismatch("unexpected result beat", {5'd0, cursor_loc}, 16'd0);
			end else begin
				want = awaited_views.pop_front();
				if (cursor_loc !== want.cursor)
					report_mismatch("cursor_loc", {5'd0, cursor_loc}, {5'd0, want.cursor});
				if (read_char !== want.ch)
					report_mismatch("read_char", {8'd0, read_char}, {8'd0, want.ch});
				if (read_style !== want.style)
					report_mismatch("read_style", {8'd0, read_style}, {8'd0, want.style});
			end
		end
	end

	// Receiver: switch between open, random, sparse and periodic stall patterns
	initial begin : drive_out_ready
		int mode;
		int span;
		int step;
		out_ready = 1'b0;
		step = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 200);
			repeat (span) begin
				@(negedge clk);
				step++;
				case (mode)
					0: out_ready = 1'b1;
					1: out_ready = 1'($urandom_range(0, 1));
					2: out_ready = ($urandom_range(0, 7) == 0);
					default: out_ready = (step % 13 >= 9);
				endcase
			end
		end
	end

	// Send one request beat, idling between bursts, and predict its result
	task automatic send_request(logic [1:0] req, logic [7:0] ch, logic [3:0] fg,
			logic [10:0] idx);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = $urandom_range(1, 20);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
			                                         : $urandom_range(1, 40);
		end
		burst_left--;
		in_valid   = 1'b1;
		req_type   = req;
		char_code  = ch;
		fg_color   = fg;
		cell_index = idx;
		do @(posedge clk); while (!in_ready);
		awaited_views.push_back(apply_request(req, ch, fg, idx));
	endtask

	// Hold the sender until every awaited result has arrived
	task automatic wait_for_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (awaited_views.size() != 0) @(posedge clk);
	endtask

	task automatic write_background(logic [3:0] value);
		@(negedge clk);
		cfg_valid        = 1'b1;
		background_color = value;
		do @(posedge clk); while (!cfg_ready);
		shadow_bg = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Cells after reset, reads beyond the grid and the unused request code
	task automatic test_reset_contents();
		send_request(REQ_READ, 8'h00, 4'h0, 11'd0);
		send_request(REQ_READ, 8'h00, 4'h0, 11'(CELLS - 1));
		send_request(REQ_READ, 8'h00, 4'h0, 11'(CELLS));
		send_request(REQ_READ, 8'h00, 4'h0, 11'h7FF);
		send_request(REQ_UNUSED, 8'hFF, 4'hF, 11'h7FF);
	endtask

	// Style bytes at the colour extremes, before and after a background write
	task automatic test_put_styles();
		send_request(REQ_PUT, 8'h41, 4'h0, 11'd0);
		send_request(REQ_PUT, 8'hFF, 4'hF, 11'd0);
		wait_for_results();
		write_background(4'hF);
		send_request(REQ_PUT, 8'h00, 4'h5, 11'd0);
		send_request(REQ_READ, 8'h00, 4'h0, 11'd0);
		send_request(REQ_READ, 8'h00, 4'h0, 11'd1);
		send_request(REQ_READ, 8'h00, 4'h0, 11'd2);
	endtask

	// Backspace either side of the margin, tabs and a newline; cursor starts at 3
	task automatic test_control_chars();
		send_request(REQ_PUT, CH_BS, 4'h0, 11'd0);
		send_request(REQ_PUT, CH_BS, 4'h0, 11'd0);
		send_request(REQ_READ, 8'h00, 4'h0, 11'd2);
		send_request(REQ_PUT, CH_TAB, 4'h0, 11'd0);
		send_request(REQ_PUT, CH_TAB, 4'h0, 11'd0);
		send_request(REQ_PUT, 8'h7E, 4'h3, 11'd0);
		send_request(REQ_PUT, CH_BS, 4'h0, 11'd0);
		send_request(REQ_PUT, CH_NL, 4'h0, 11'd0);
		send_request(REQ_PUT, CH_BS, 4'h0, 11'd0);
	endtask

	// Walk down to the last row, scroll with a newline, then clear
	task automatic test_scroll();
		repeat (ROWS - 2) send_request(REQ_PUT, CH_NL, 4'h0, 11'd0);
		send_request(REQ_PUT, 8'h55, 4'hA, 11'd0);
		send_request(REQ_PUT, CH_NL, 4'h0, 11'd0);
		send_request(REQ_READ, 8'h00, 4'h0, 11'(CELLS - 2 * COLUMNS));
		send_request(REQ_READ, 8'h00, 4'h0, 11'(CELLS - COLUMNS));
		send_request(REQ_CLEAR, 8'h00, 4'h0, 11'd0);
		send_request(REQ_READ, 8'h00, 4'h0, 11'(CELLS - 2 * COLUMNS));
	endtask

	task automatic run_random_items(int count);
		int pick;
		int back;
		logic [1:0]  req;
		logic [7:0]  ch;
		logic [3:0]  fg;
		logic [10:0] idx;
		repeat (count) begin
			req  = REQ_PUT;
			ch   = 8'($urandom_range(0, 255));
			fg   = 4'($urandom_range(0, 15));
			idx  = 11'($urandom_range(0, 2047));
			pick = $urandom_range(0, 999);
			if (scrolls_seen >= SCROLL_CAP && shadow_cursor >= CELLS - COLUMNS) begin
				req = REQ_CLEAR;
			end else if (pick < 300) begin
				req = REQ_READ;
				case ($urandom_range(0, 7))
					0: ;
					1, 2, 3: begin
						// look just behind the cursor, where the writes land
						back = $urandom_range(0, 40);
						idx  = (shadow_cursor >= back) ? 11'(shadow_cursor - back) : 11'd0;
					end
					default: idx = 11'($urandom_range(0, CELLS - 1));
				endcase
			end else if (pick < 370) begin
				ch = CH_BS;
			end else if (pick < 430) begin
				ch = CH_TAB;
			end else if (pick < 510) begin
				ch = CH_NL;
			end else if (pick < 512) begin
				req = REQ_CLEAR;
			end else if (pick < 522) begin
				req = REQ_UNUSED;
			end
			if ($urandom_range(0, 149) == 0)
				wait_for_results();
			send_request(req, ch, fg, idx);
		end
	endtask

	// Random phases, each under its own background colour
	task automatic test_random();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_for_results();
			case (phase)
				0: write_background(4'h0);
				2: write_background(4'hF);
				default: write_background(4'($urandom_range(1, 14)));
			endcase
			run_random_items(RANDOM_PHASE_ITEMS);
		end
	endtask

	initial begin
		in_valid         = 1'b0;
		req_type         = REQ_PUT;
		char_code        = 8'h00;
		fg_color         = 4'h0;
		cell_index       = 11'd0;
		cfg_valid        = 1'b0;
		background_color = 4'h0;
		arst_n           = 1'b0;
		mismatches       = 0;
		scrolls_seen     = 0;
		burst_left       = 0;
		shadow_bg        = 4'h0;
		blank_screen();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_contents();
		test_put_styles();
		test_control_chars();
		test_scroll();
		test_random();

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited_views.size() == 0)
			$display("text_mode_console_writer_test: PASS");
		else
			$display("text_mode_console_writer_test: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/tmcw_pkg.sv
sv/tmcw_dp.sv
sv/tmcw_ctrl.sv
sv/text_mode_console_writer.sv
sv/tmcw_checker.sv
tb/sv/text_mode_console_writer_test.sv
